// ===== src/plcs_pkg.sv =====
// ============================================================================
// plcs_pkg - per-class latency statistics shared definitions
// Operation codes and the fixed field widths of the record and result channels.
// ============================================================================
`default_nettype none

package plcs_pkg;

    // op field
    localparam int OP_W    = 2;
    localparam int CLASS_W = 8;
    localparam int CNT_W   = 32;
    localparam int SUM_W   = 64;

    localparam logic [OP_W-1:0] OP_IMM = 2'd0;  // immediate completion record
    localparam logic [OP_W-1:0] OP_DEF = 2'd1;  // deferred completion record
    // the two remaining codes read one class entry

endpackage

`default_nettype wire

// ===== src/plcs_in_if.sv =====
// ============================================================================
// plcs_in_if - completion record channel
// valid/ready channel carrying one record or read request per transfer.
// ============================================================================
`default_nettype none

interface plcs_in_if #(
    parameter int TIME_BITS = 48
);
    logic                          valid;
    logic                          ready;
    logic [plcs_pkg::OP_W-1:0]     op;
    logic [plcs_pkg::CLASS_W-1:0]  item_class;
    logic [TIME_BITS-1:0]          created_at;
    logic [TIME_BITS-1:0]          started_at;
    logic [TIME_BITS-1:0]          finished_at;

    modport source (
        output valid, op, item_class, created_at, started_at, finished_at,
        input  ready
    );

    modport sink (
        input  valid, op, item_class, created_at, started_at, finished_at,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/plcs_out_if.sv =====
// ============================================================================
// plcs_out_if - statistics result channel
// valid/ready channel carrying one class entry snapshot and totals per transfer.
// ============================================================================
`default_nettype none

interface plcs_out_if #(
    parameter int TIME_BITS = 48
);
    logic                                valid;
    logic                                ready;
    logic                                class_ok;
    logic        [plcs_pkg::CNT_W-1:0]   class_count;
    logic signed [plcs_pkg::SUM_W-1:0]   queue_sum;
    logic signed [TIME_BITS-1:0]         queue_min;
    logic signed [TIME_BITS-1:0]         queue_max;
    logic signed [plcs_pkg::SUM_W-1:0]   exec_sum;
    logic signed [TIME_BITS-1:0]         exec_min;
    logic signed [TIME_BITS-1:0]         exec_max;
    logic signed [TIME_BITS-1:0]         adjusted_queue_time;
    logic        [plcs_pkg::CNT_W-1:0]   immediate_count;
    logic        [plcs_pkg::CNT_W-1:0]   deferred_count;

    modport source (
        output valid, class_ok, class_count, queue_sum, queue_min, queue_max,
               exec_sum, exec_min, exec_max, adjusted_queue_time,
               immediate_count, deferred_count,
        input  ready
    );

    modport sink (
        input  valid, class_ok, class_count, queue_sum, queue_min, queue_max,
               exec_sum, exec_min, exec_max, adjusted_queue_time,
               immediate_count, deferred_count,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/plcs_ram.sv =====
// ============================================================================
// plcs_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ============================================================================
`default_nettype none

module plcs_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/per_class_latency_statistics_top.sv =====
// ============================================================================
// per_class_latency_statistics_top - per-class queue/exec latency statistics
// Keeps count, saturating sums and min/max of queue and execution time per class.
// ============================================================================
// Sequence: the input transfer issues the RAM read, S_CALC1 and S_CALC2 compute,
//   S_UPD writes back and S_OUT loads the output register, waiting while it is
//   full and not drained; one record at a time goes through the single entry RAM.
// Reset (synchronous, active low): clears the totals, the status-run record,
//   the config register and one valid bit per class; an entry whose valid bit
//   is clear reads as all zero, so no clearing pass is needed.
// ============================================================================
`default_nettype none

module per_class_latency_statistics_top #(
    parameter int NUM_CLASSES = 64,
    parameter int TIME_BITS   = 48
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [plcs_pkg::CLASS_W-1:0]   i_cfg_wdata,
    plcs_in_if.sink                             i_in,
    plcs_out_if.source                          o_out
);

    localparam int TB     = TIME_BITS;
    localparam int CNT_W  = plcs_pkg::CNT_W;
    localparam int SUM_W  = plcs_pkg::SUM_W;
    localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

    localparam logic [TB-1:0] T_MAX = {1'b0, {(TB-1){1'b1}}};
    localparam logic [TB-1:0] T_MIN = {1'b1, {(TB-1){1'b0}}};
    localparam logic [SUM_W-1:0] S_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] S_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for a record
    localparam logic [2:0] S_CALC1 = 3'd1;  // RAM data back, raw differences
    localparam logic [2:0] S_CALC2 = 3'd2;  // overlap deduction and clamp
    localparam logic [2:0] S_UPD   = 3'd3;  // entry update, write-back
    localparam logic [2:0] S_OUT   = 3'd4;  // hand result to output register

    // one class entry as stored in the RAM
    typedef struct packed {
        logic        [CNT_W-1:0] cnt;
        logic signed [SUM_W-1:0] qsum;
        logic signed [TB-1:0]    qmin;
        logic signed [TB-1:0]    qmax;
        logic signed [SUM_W-1:0] esum;
        logic signed [TB-1:0]    emin;
        logic signed [TB-1:0]    emax;
    } t_entry;

    // one result item
    typedef struct packed {
        logic                    ok;
        t_entry                  entry;
        logic signed [TB-1:0]    adj;
        logic        [CNT_W-1:0] imm_total;
        logic        [CNT_W-1:0] def_total;
    } t_res;

    // saturating signed 64-bit add
    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W-1:0] s;
        s = a + b;
        if ((a[SUM_W-1] == b[SUM_W-1]) && (s[SUM_W-1] != a[SUM_W-1])) begin
            s = a[SUM_W-1] ? S_MIN : S_MAX;
        end
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [2:0]                       r_state, n_state;
    logic [plcs_pkg::CLASS_W-1:0]     r_status_class;

    // captured record
    logic [plcs_pkg::OP_W-1:0]        r_op;
    logic [plcs_pkg::CLASS_W-1:0]     r_cls;
    logic                             r_ok;
    logic                             r_is_status;
    logic                             r_vld;
    logic [TB-1:0]                    r_created;
    logic [TB-1:0]                    r_started;
    logic [TB-1:0]                    r_finished;

    // intermediate results
    t_entry                           r_entry;
    logic signed [TB:0]               r_qraw;
    logic signed [TB:0]               r_ded;
    logic                             r_apply;
    logic signed [TB-1:0]             r_e;
    logic signed [TB-1:0]             r_q;

    // global state
    logic [NUM_CLASSES-1:0]           r_valid;
    logic [CNT_W-1:0]                 r_imm_total, n_imm_total;
    logic [CNT_W-1:0]                 r_def_total, n_def_total;
    logic [TB-1:0]                    r_st_start;
    logic [TB-1:0]                    r_st_finish;
    logic signed [TB-1:0]             r_st_run;

    // result staging and output register
    t_res                             r_res, n_res;
    t_res                             r_out;
    logic                             r_out_valid;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic in_acc;
    logic out_load;

    // one record in flight at a time; the output register decouples the
    // sink side so a waiting result does not hold off the next record
    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_load   = (r_state == S_OUT) && (!r_out_valid || o_out.ready);

    // ------------------------------------------------------------------
    // Entry RAM: read issued on the input transfer, written in S_UPD
    // ------------------------------------------------------------------
    logic                       ram_we;
    logic [$bits(t_entry)-1:0]  ram_rdata;
    t_entry                     new_entry;

    plcs_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (NUM_CLASSES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cls[CLS_W-1:0]),
        .i_wdata (new_entry),
        .i_re    (in_acc),
        .i_raddr (i_in.item_class[CLS_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // S_CALC1: raw queue time, deduction candidate, clamped exec time
    // ------------------------------------------------------------------
    logic signed [TB:0]   q_raw_c;
    logic signed [TB:0]   e_diff_c;
    logic signed [TB:0]   ded_c;
    logic                 apply_c;
    logic signed [TB-1:0] e_clamp_c;

    always_comb begin
        q_raw_c  = $signed({1'b0, r_started})  - $signed({1'b0, r_created});
        e_diff_c = $signed({1'b0, r_finished}) - $signed({1'b0, r_started});
        // status run started inside the queue wait: deduct all of it,
        // else only the part after creation
        if (r_st_start >= r_created) begin
            ded_c = {r_st_run[TB-1], r_st_run};
        end else begin
            ded_c = $signed({1'b0, r_st_finish}) - $signed({1'b0, r_created});
        end
        apply_c = !r_is_status && (r_st_finish > r_created);
        if (e_diff_c[TB] != e_diff_c[TB-1]) begin
            e_clamp_c = e_diff_c[TB] ? T_MIN : T_MAX;
        end else begin
            e_clamp_c = e_diff_c[TB-1:0];
        end
    end

    // ------------------------------------------------------------------
    // S_CALC2: apply deduction, clamp to the time range
    // ------------------------------------------------------------------
    logic signed [TB+1:0] q_diff_c;
    logic signed [TB-1:0] q_clamp_c;

    always_comb begin
        if (r_apply) begin
            q_diff_c = {r_qraw[TB], r_qraw} - {r_ded[TB], r_ded};
        end else begin
            q_diff_c = {r_qraw[TB], r_qraw};
        end
        if ((q_diff_c[TB+1:TB-1] == 3'b000) || (q_diff_c[TB+1:TB-1] == 3'b111)) begin
            q_clamp_c = q_diff_c[TB-1:0];
        end else begin
            q_clamp_c = q_diff_c[TB+1] ? T_MIN : T_MAX;
        end
    end

    // ------------------------------------------------------------------
    // S_UPD: entry update, totals, result
    // ------------------------------------------------------------------
    logic upd;
    logic first;

    always_comb begin
        upd   = (r_state == S_UPD) && (r_op == plcs_pkg::OP_IMM) && r_ok;
        first = (r_entry.cnt == '0);

        new_entry = r_entry;
        if (upd) begin
            if (r_entry.cnt != '1) begin
                new_entry.cnt = r_entry.cnt + 1'b1;
            end
            // first record of a class seeds min and max
            if (first || ($signed(r_q) < $signed(r_entry.qmin))) begin
                new_entry.qmin = r_q;
            end
            if (first || ($signed(r_q) > $signed(r_entry.qmax))) begin
                new_entry.qmax = r_q;
            end
            if (first || ($signed(r_e) < $signed(r_entry.emin))) begin
                new_entry.emin = r_e;
            end
            if (first || ($signed(r_e) > $signed(r_entry.emax))) begin
                new_entry.emax = r_e;
            end
            new_entry.qsum = sat_add(r_entry.qsum, {{(SUM_W-TB){r_q[TB-1]}}, r_q});
            new_entry.esum = sat_add(r_entry.esum, {{(SUM_W-TB){r_e[TB-1]}}, r_e});
        end

        n_imm_total = r_imm_total;
        if (upd && (r_imm_total != '1)) begin
            n_imm_total = r_imm_total + 1'b1;
        end
        // deferred records count whatever their class
        n_def_total = r_def_total;
        if ((r_state == S_UPD) && (r_op == plcs_pkg::OP_DEF) && (r_def_total != '1)) begin
            n_def_total = r_def_total + 1'b1;
        end

        n_res.ok        = r_ok;
        n_res.entry     = r_ok ? new_entry : '0;
        n_res.adj       = upd ? r_q : '0;
        n_res.imm_total = n_imm_total;
        n_res.def_total = n_def_total;
    end

    assign ram_we = upd;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_CALC1;
                end
            end
            S_CALC1: n_state = S_CALC2;
            S_CALC2: n_state = S_UPD;
            S_UPD:   n_state = S_OUT;
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_status_class <= '0;
            r_valid        <= '0;
            r_imm_total    <= '0;
            r_def_total    <= '0;
            r_st_start     <= '0;
            r_st_finish    <= '0;
            r_st_run       <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_imm_total <= n_imm_total;
            r_def_total <= n_def_total;
            if (i_cfg_we) begin
                r_status_class <= i_cfg_wdata;
            end
            if (ram_we) begin
                r_valid[r_cls[CLS_W-1:0]] <= 1'b1;
            end
            // last run of the status class, seen by later records
            if (upd && r_is_status) begin
                r_st_start  <= r_started;
                r_st_finish <= r_finished;
                r_st_run    <= r_e;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op        <= i_in.op;
            r_cls       <= i_in.item_class;
            r_ok        <= ({1'b0, i_in.item_class} < (plcs_pkg::CLASS_W+1)'(NUM_CLASSES));
            r_is_status <= (i_in.item_class == r_status_class);
            r_vld       <= r_valid[i_in.item_class[CLS_W-1:0]];
            r_created   <= i_in.created_at;
            r_started   <= i_in.started_at;
            r_finished  <= i_in.finished_at;
        end
        if (r_state == S_CALC1) begin
            r_entry <= r_vld ? t_entry'(ram_rdata) : '0;
            r_qraw  <= q_raw_c;
            r_ded   <= ded_c;
            r_apply <= apply_c;
            r_e     <= e_clamp_c;
        end
        if (r_state == S_CALC2) begin
            r_q <= q_clamp_c;
        end
        if (r_state == S_UPD) begin
            r_res <= n_res;
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    // ------------------------------------------------------------------
    // Output port
    // ------------------------------------------------------------------
    assign o_out.valid               = r_out_valid;
    assign o_out.class_ok            = r_out.ok;
    assign o_out.class_count         = r_out.entry.cnt;
    assign o_out.queue_sum           = r_out.entry.qsum;
    assign o_out.queue_min           = r_out.entry.qmin;
    assign o_out.queue_max           = r_out.entry.qmax;
    assign o_out.exec_sum            = r_out.entry.esum;
    assign o_out.exec_min            = r_out.entry.emin;
    assign o_out.exec_max            = r_out.entry.emax;
    assign o_out.adjusted_queue_time = r_out.adj;
    assign o_out.immediate_count     = r_out.imm_total;
    assign o_out.deferred_count      = r_out.def_total;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in.ready)
        else $error("second record taken while one is in flight");

    a_wb_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (new_entry.cnt != '0))
        else $error("entry written back with zero count");

    a_wb_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (($signed(new_entry.qmin) <= $signed(new_entry.qmax)) &&
                    ($signed(new_entry.emin) <= $signed(new_entry.emax))))
        else $error("entry written back with min above max");

    a_imm_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_imm_total >= $past(r_imm_total)))
        else $error("immediate total went backward");

endmodule

`default_nettype wire

// ===== verif/plcs_stats_checker.sv =====
// ============================================================================
// plcs_stats_checker - scoreboard for the per-class latency statistics block
// Watches the record and result channels and the status class register,
// keeps its own copy of the per-class tables and totals, predicts one result
// per accepted transfer and compares every result field by field, in order.
// ============================================================================

module plcs_stats_checker #(
    parameter int NUM_CLASSES = 64,
    parameter int TIME_BITS   = 48
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [plcs_pkg::CLASS_W-1:0]   i_cfg_wdata,
    plcs_in_if                                  in_mon,
    plcs_out_if                                 out_mon,
    output int                                  o_mismatch_count,
    output int                                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OP_W    = plcs_pkg::OP_W;
    localparam int CLASS_W = plcs_pkg::CLASS_W;
    localparam int CNT_W   = plcs_pkg::CNT_W;
    localparam int SUM_W   = plcs_pkg::SUM_W;

    localparam longint T_MAX   = (longint'(1) <<< (TIME_BITS - 1)) - 1;
    localparam longint T_MIN   = -T_MAX - 1;
    localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint SUM_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic                 class_ok;
        logic [CNT_W-1:0]     class_count;
        logic [SUM_W-1:0]     queue_sum;
        logic [TIME_BITS-1:0] queue_min;
        logic [TIME_BITS-1:0] queue_max;
        logic [SUM_W-1:0]     exec_sum;
        logic [TIME_BITS-1:0] exec_min;
        logic [TIME_BITS-1:0] exec_max;
        logic [TIME_BITS-1:0] adjusted_queue_time;
        logic [CNT_W-1:0]     immediate_count;
        logic [CNT_W-1:0]     deferred_count;
    } t_stats_result;

    // shadow statistics
    logic [CLASS_W-1:0]   status_class;
    logic [CNT_W-1:0]     count_tab [NUM_CLASSES];
    longint               qsum_tab  [NUM_CLASSES];
    longint               qmin_tab  [NUM_CLASSES];
    longint               qmax_tab  [NUM_CLASSES];
    longint               esum_tab  [NUM_CLASSES];
    longint               emin_tab  [NUM_CLASSES];
    longint               emax_tab  [NUM_CLASSES];
    logic [CNT_W-1:0]     immediate_total;
    logic [CNT_W-1:0]     deferred_total;
    logic [TIME_BITS-1:0] status_start;
    logic [TIME_BITS-1:0] status_finish;
    longint               status_run;

    t_stats_result expected_stats_q [$];
    int            mismatches = 0;

    assign o_mismatch_count = mismatches;

    function automatic longint time_diff(input logic [TIME_BITS-1:0] a,
                                         input logic [TIME_BITS-1:0] b);
        return longint'(64'(a)) - longint'(64'(b));
    endfunction

    function automatic longint clamp_time(input longint v);
        if (v > T_MAX) return T_MAX;
        if (v < T_MIN) return T_MIN;
        return v;
    endfunction

    function automatic longint add_sat64(input longint a, input longint b);
        longint s;
        s = a + b;
        if (a >= 0 && b >= 0 && s < 0) return SUM_MAX;
        if (a < 0 && b < 0 && s >= 0) return SUM_MIN;
        return s;
    endfunction

    function automatic void clear_stats();
        status_class    = '0;
        immediate_total = '0;
        deferred_total  = '0;
        status_start    = '0;
        status_finish   = '0;
        status_run      = 0;
        for (int k = 0; k < NUM_CLASSES; k++) begin
            count_tab[k] = '0;
            qsum_tab[k]  = 0;
            qmin_tab[k]  = 0;
            qmax_tab[k]  = 0;
            esum_tab[k]  = 0;
            emin_tab[k]  = 0;
            emax_tab[k]  = 0;
        end
    endfunction

    function automatic t_stats_result predict_stats(
        input logic [OP_W-1:0]      op,
        input logic [CLASS_W-1:0]   cls,
        input logic [TIME_BITS-1:0] created,
        input logic [TIME_BITS-1:0] started,
        input logic [TIME_BITS-1:0] finished
    );
        t_stats_result r;
        logic          in_range;
        logic          is_status;
        longint        q;
        longint        e;
        longint        adj;
        r        = '0;
        adj      = 0;
        in_range = (int'(cls) < NUM_CLASSES);
        if (op == plcs_pkg::OP_DEF) begin
            if (deferred_total != '1) deferred_total++;
        end else if (op == plcs_pkg::OP_IMM && in_range) begin
            is_status = (cls == status_class);
            q = time_diff(started, created);
            e = clamp_time(time_diff(finished, started));
            // deduct the overlap with the last status run; operands stay far
            // below the 64-bit limits, so a plain subtract is exact
            if (!is_status && status_finish > created) begin
                if (status_start >= created)
                    q = q - status_run;
                else
                    q = q - time_diff(status_finish, created);
            end
            q   = clamp_time(q);
            adj = q;
            if (immediate_total != '1) immediate_total++;
            if (count_tab[cls] == '0) begin
                qmin_tab[cls] = q;
                qmax_tab[cls] = q;
                emin_tab[cls] = e;
                emax_tab[cls] = e;
            end else begin
                if (q < qmin_tab[cls]) qmin_tab[cls] = q;
                if (q > qmax_tab[cls]) qmax_tab[cls] = q;
                if (e < emin_tab[cls]) emin_tab[cls] = e;
                if (e > emax_tab[cls]) emax_tab[cls] = e;
            end
            if (count_tab[cls] != '1) count_tab[cls]++;
            qsum_tab[cls] = add_sat64(qsum_tab[cls], q);
            esum_tab[cls] = add_sat64(esum_tab[cls], e);
            if (is_status) begin
                status_start  = started;
                status_finish = finished;
                status_run    = e;
            end
        end
        if (in_range) begin
            r.class_ok    = 1'b1;
            r.class_count = count_tab[cls];
            r.queue_sum   = qsum_tab[cls];
            r.queue_min   = TIME_BITS'(qmin_tab[cls]);
            r.queue_max   = TIME_BITS'(qmax_tab[cls]);
            r.exec_sum    = esum_tab[cls];
            r.exec_min    = TIME_BITS'(emin_tab[cls]);
            r.exec_max    = TIME_BITS'(emax_tab[cls]);
        end
        r.adjusted_queue_time = TIME_BITS'(adj);
        r.immediate_count     = immediate_total;
        r.deferred_count      = deferred_total;
        return r;
    endfunction

    function automatic void compare_field(input string name,
                                          input logic [63:0] want,
                                          input logic [63:0] got);
        if (got !== want) begin
            if (mismatches < 10)
                $display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_stats_result want;
        t_stats_result got;
        if (!i_rst_n) begin
            clear_stats();
            expected_stats_q.delete();
        end else begin
            if (i_cfg_we) status_class = i_cfg_wdata;
            if (in_mon.valid && in_mon.ready)
                expected_stats_q.push_back(predict_stats(in_mon.op, in_mon.item_class,
                    in_mon.created_at, in_mon.started_at, in_mon.finished_at));
            if (out_mon.valid && out_mon.ready) begin
                got.class_ok            = out_mon.class_ok;
                got.class_count         = out_mon.class_count;
                got.queue_sum           = out_mon.queue_sum;
                got.queue_min           = out_mon.queue_min;
                got.queue_max           = out_mon.queue_max;
                got.exec_sum            = out_mon.exec_sum;
                got.exec_min            = out_mon.exec_min;
                got.exec_max            = out_mon.exec_max;
                got.adjusted_queue_time = out_mon.adjusted_queue_time;
                got.immediate_count     = out_mon.immediate_count;
                got.deferred_count      = out_mon.deferred_count;
                if (expected_stats_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result transfer with nothing expected", $realtime);
                    mismatches++;
                end else begin
                    want = expected_stats_q.pop_front();
                    compare_field("class_ok", 64'(want.class_ok), 64'(got.class_ok));
                    compare_field("class_count", 64'(want.class_count),
                                  64'(got.class_count));
                    compare_field("queue_sum", want.queue_sum, got.queue_sum);
                    compare_field("queue_min", 64'(want.queue_min), 64'(got.queue_min));
                    compare_field("queue_max", 64'(want.queue_max), 64'(got.queue_max));
                    compare_field("exec_sum", want.exec_sum, got.exec_sum);
                    compare_field("exec_min", 64'(want.exec_min), 64'(got.exec_min));
                    compare_field("exec_max", 64'(want.exec_max), 64'(got.exec_max));
                    compare_field("adjusted_queue_time", 64'(want.adjusted_queue_time),
                                  64'(got.adjusted_queue_time));
                    compare_field("immediate_count", 64'(want.immediate_count),
                                  64'(got.immediate_count));
                    compare_field("deferred_count", 64'(want.deferred_count),
                                  64'(got.deferred_count));
                end
            end
        end
        o_pending = expected_stats_q.size();
    end

endmodule

// ===== verif/tb_per_class_latency_statistics_top.sv =====
// ============================================================================
// tb_per_class_latency_statistics_top - stimulus and verdict
// Drives completion records, deferred records and class reads into the block
// with random gaps and random result back-pressure, sweeps the status class
// register over several values, and reports the checker's outcome.
// ============================================================================

module tb_per_class_latency_statistics_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OP_W            = plcs_pkg::OP_W;
    localparam int CLASS_W         = plcs_pkg::CLASS_W;
    localparam int NUM_CLASSES     = 64;
    localparam int TIME_BITS       = 48;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 192;
    localparam int MAX_WAIT        = 17;   // longest gap / stall per transfer
    localparam int SETTLE_CYCLES   = 8;    // extra wait once every result is seen
    localparam int WATCHDOG_LIMIT  = 2000; // cycles without any transfer

    // both read codes; the package only names the two record codes
    localparam logic [OP_W-1:0] OP_READ     = 2'd2;
    localparam logic [OP_W-1:0] OP_READ_ALT = 2'd3;

    localparam logic [TIME_BITS-1:0] T_ZERO = '0;
    localparam logic [TIME_BITS-1:0] T_ONES = '1;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CLASS_W-1:0] i_cfg_wdata;

    plcs_in_if  #(.TIME_BITS(TIME_BITS)) in_ch ();
    plcs_out_if #(.TIME_BITS(TIME_BITS)) out_ch ();

    int mismatch_count;
    int pending_results;
    int idle_cycles;

    // stimulus-side view of the register, only used to aim records at it
    logic [CLASS_W-1:0]   status_class_now;
    // running "wall clock" for well-formed record timestamps
    logic [TIME_BITS-1:0] wall_clock;
    // when set, neither side inserts gaps or stalls
    bit                   burst_mode;

    per_class_latency_statistics_top #(
        .NUM_CLASSES (NUM_CLASSES),
        .TIME_BITS   (TIME_BITS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    plcs_stats_checker #(
        .NUM_CLASSES (NUM_CLASSES),
        .TIME_BITS   (TIME_BITS)
    ) stats_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .in_mon           (in_ch),
        .out_mon          (out_ch),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending_results)
    );

    // 8 ns clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: any transfer on either channel restarts the count. A hung
    // block or a lost result stops the run here.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Result side: a fresh stall for every result transfer. ready is only
    // touched at falling edges, and left high when the next stall is zero.
    initial begin : result_sink
        int stall;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = burst_mode ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    function automatic logic [TIME_BITS-1:0] rand_time();
        return TIME_BITS'({$urandom, $urandom});
    endfunction

    // Noise timestamps: mostly anything, sometimes the two extremes.
    function automatic logic [TIME_BITS-1:0] noise_time();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return T_ZERO;
        if (pick == 1) return T_ONES;
        return rand_time();
    endfunction

    // One record transfer. Entered just after a rising edge (or at start);
    // returns right after the edge at which the record was accepted, with
    // valid still high so back-to-back transfers need no extra step.
    task automatic send_record(input logic [OP_W-1:0]      op,
                               input logic [CLASS_W-1:0]   cls,
                               input logic [TIME_BITS-1:0] created,
                               input logic [TIME_BITS-1:0] started,
                               input logic [TIME_BITS-1:0] finished);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, MAX_WAIT);
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.op          <= op;
        in_ch.item_class  <= cls;
        in_ch.created_at  <= created;
        in_ch.started_at  <= started;
        in_ch.finished_at <= finished;
        in_ch.valid       <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Stop sending and hold off until every predicted result has been seen,
    // then let the pipe settle so the block is idle.
    task automatic wait_until_drained();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_results != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Register write; only called with the block idle.
    task automatic write_status_class(input logic [CLASS_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        status_class_now = value;
    endtask

    // Random traffic. Most records are well formed: timestamps ordered and
    // close to a moving wall clock, with a good share aimed at the status
    // class, so queue windows overlap status runs in every possible way.
    // The rest is noise: arbitrary 48-bit timestamps, which drive the time
    // differences into both clamps.
    task automatic send_random_record();
        int                   pick;
        logic [OP_W-1:0]      op;
        logic [CLASS_W-1:0]   cls;
        logic [TIME_BITS-1:0] created;
        logic [TIME_BITS-1:0] started;
        logic [TIME_BITS-1:0] finished;

        if ($urandom_range(0, 39) == 0) burst_mode = ~burst_mode;

        pick = $urandom_range(0, 99);
        if (pick < 60)      op = plcs_pkg::OP_IMM;
        else if (pick < 75) op = plcs_pkg::OP_DEF;
        else if (pick < 88) op = OP_READ;
        else                op = OP_READ_ALT;

        pick = $urandom_range(0, 99);
        if (pick < 35)      cls = status_class_now;
        else if (pick < 70) cls = CLASS_W'($urandom_range(0, 7));
        else if (pick < 92) cls = CLASS_W'($urandom_range(0, NUM_CLASSES - 1));
        else                cls = CLASS_W'($urandom_range(NUM_CLASSES, 255));

        if ($urandom_range(0, 99) < 80) begin
            created    = wall_clock - TIME_BITS'($urandom_range(0, 3000));
            started    = created + TIME_BITS'($urandom_range(0, 4000));
            finished   = started + TIME_BITS'($urandom_range(0, 4000));
            wall_clock = wall_clock + TIME_BITS'($urandom_range(0, 2500));
        end else begin
            created  = noise_time();
            started  = noise_time();
            finished = noise_time();
        end
        send_record(op, cls, created, started, finished);

        // now and then the sender waits for the whole backlog to drain
        if ($urandom_range(0, 149) == 0) wait_until_drained();
    endtask

    initial begin : stimulus
        logic [CLASS_W-1:0] phase_cfg [PHASES];

        // every block input at a known value from time zero
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        in_ch.valid       = 1'b0;
        in_ch.op          = plcs_pkg::OP_IMM;
        in_ch.item_class  = '0;
        in_ch.created_at  = '0;
        in_ch.started_at  = '0;
        in_ch.finished_at = '0;
        burst_mode        = 1'b0;
        status_class_now  = '0;
        wall_clock        = rand_time() >> 2;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed part, status class 5 ----
        write_status_class(CLASS_W'(5));

        // read of a class that was never written reads as zero
        send_record(OP_READ, 8'd0, T_ZERO, T_ZERO, T_ZERO);
        // first record sets min/max, later ones move them
        send_record(plcs_pkg::OP_IMM, 8'd3, 48'd100, 48'd400, 48'd900);
        send_record(plcs_pkg::OP_IMM, 8'd3, 48'd200, 48'd250, 48'd2000);
        send_record(plcs_pkg::OP_IMM, 8'd3, 48'd0, 48'd5000, 48'd5001);
        // out-of-range classes: immediate records ignored, deferred counted
        send_record(plcs_pkg::OP_IMM, 8'd64, 48'd10, 48'd20, 48'd30);
        send_record(plcs_pkg::OP_IMM, 8'd255, T_ONES, T_ONES, T_ONES);
        send_record(plcs_pkg::OP_DEF, 8'd200, 48'd1, 48'd2, 48'd3);
        send_record(plcs_pkg::OP_DEF, 8'd3, T_ONES, T_ZERO, T_ONES);
        // the alternate read code, and a read out of range
        send_record(OP_READ_ALT, 8'd3, T_ZERO, T_ZERO, T_ZERO);
        send_record(OP_READ, 8'd255, T_ONES, T_ONES, T_ONES);
        // time differences clamped at both ends of the signed range
        send_record(plcs_pkg::OP_IMM, 8'd10, T_ZERO, T_ONES, T_ZERO);
        send_record(plcs_pkg::OP_IMM, 8'd10, T_ONES, T_ZERO, T_ONES);
        // status run 1000..2000 (run time 1000)
        send_record(plcs_pkg::OP_IMM, 8'd5, 48'd100, 48'd1000, 48'd2000);
        // queued before the run started: whole run deducted
        send_record(plcs_pkg::OP_IMM, 8'd7, 48'd500, 48'd3000, 48'd3100);
        // created exactly at run start: still the whole run
        send_record(plcs_pkg::OP_IMM, 8'd7, 48'd1000, 48'd3000, 48'd3100);
        // created mid-run: only the tail of the run is deducted
        send_record(plcs_pkg::OP_IMM, 8'd7, 48'd1500, 48'd2500, 48'd2600);
        // created exactly at run finish: no deduction
        send_record(plcs_pkg::OP_IMM, 8'd7, 48'd2000, 48'd2500, 48'd2600);
        // deduction larger than the queue time: negative result
        send_record(plcs_pkg::OP_IMM, 8'd7, 48'd900, 48'd950, 48'd960);
        // status record overlapping its own last run: never deducted;
        // finish before start leaves a negative run time
        send_record(plcs_pkg::OP_IMM, 8'd5, 48'd50, 48'd3000, 48'd2500);
        // deducting a negative run time adds to the queue time
        send_record(plcs_pkg::OP_IMM, 8'd8, 48'd2000, 48'd2200, 48'd2300);
        // deduction pushes an already huge queue time past the clamp
        send_record(plcs_pkg::OP_IMM, 8'd6, T_ZERO, T_ONES, T_ONES);
        send_record(OP_READ, 8'd7, T_ZERO, T_ZERO, T_ZERO);
        send_record(plcs_pkg::OP_DEF, 8'd63, T_ZERO, T_ZERO, T_ZERO);

        // ---- random part, one register setting per phase ----
        phase_cfg[0] = CLASS_W'(0);
        phase_cfg[1] = CLASS_W'(255);
        phase_cfg[2] = CLASS_W'(NUM_CLASSES - 1);
        phase_cfg[3] = CLASS_W'($urandom_range(0, NUM_CLASSES - 1));
        phase_cfg[4] = CLASS_W'(1);
        phase_cfg[5] = CLASS_W'($urandom_range(0, 255));

        for (int p = 0; p < PHASES; p++) begin
            wait_until_drained();
            write_status_class(phase_cfg[p]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_random_record();
        end

        // ---- wind down and verdict ----
        wait_until_drained();
        if (mismatch_count == 0 && pending_results == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== per_class_latency_statistics_top.f =====
src/plcs_pkg.sv
src/plcs_in_if.sv
src/plcs_out_if.sv
src/plcs_ram.sv
src/per_class_latency_statistics_top.sv
verif/plcs_stats_checker.sv
verif/tb_per_class_latency_statistics_top.sv
